>>> sv/pose_rebase_to_first_frame_macros.svh
// Assertion macros shared by the checker of the pose rebase block.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef POSE_REBASE_TO_FIRST_FRAME_MACROS_SVH
`define POSE_REBASE_TO_FIRST_FRAME_MACROS_SVH
`define PR_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define PR_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

>>> sv/prf_pkg.sv
// Package for the pose rebase block: types, widths and fixed-point helpers.
// Depends on nothing; used by every module of the block.
`default_nettype none
package prf_pkg;
  localparam int PosW = 32;
  localparam int QuatW = 16;
  localparam int One14 = 16384;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MAT, ST_REF, ST_TRN, ST_REL, ST_POS, ST_SQRT, ST_DIV, ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    OP_NONE, OP_SQRT, OP_DIV
  } op_t;

  typedef struct packed {
    logic        start;
    op_t         op;
    logic [31:0] num;
    logic [31:0] den;
  } srq_t;

  typedef struct packed {
    logic        done;
    logic [31:0] res;
  } srs_t;

  function automatic logic signed [15:0] sat14(input logic signed [63:0] v);
    logic signed [15:0] r;
    if (v > 64'sd16384) r = 16'sd16384;
    else if (v < -64'sd16384) r = -16'sd16384;
    else r = v[15:0];
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) r = 32'sh7fffffff;
    else if (v < -64'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [63:0] rsh14(input logic signed [63:0] v);
    logic signed [63:0] t;
    t = v + 64'sd8192;
    return t >>> 14;
  endfunction
endpackage
`default_nettype wire

>>> sv/prf_mul.sv
// Bit-serial signed multiplier: 32 x 32 bits, one multiplier bit per cycle.
// Depends on prf_pkg.
`default_nettype none
module prf_mul (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic signed [31:0] a,
  input  wire logic signed [31:0] b,
  output logic                    done,
  output logic signed [63:0]      prod
);
  import prf_pkg::*;
  logic [5:0]         cnt;
  logic               busy;
  logic [31:0]        mb;
  logic signed [63:0] ma;
  logic signed [63:0] acc;
  logic               neg;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= 6'd0;
        acc <= '0;
        neg <= a[31] ^ b[31];
        ma <= a[31] ? -64'(a) : 64'(a);
        mb <= b[31] ? 32'(-b) : 32'(b);
      end else if (busy) begin
        if (mb[0]) acc <= acc + ma;
        ma <= ma <<< 1;
        mb <= mb >> 1;
        cnt <= cnt + 6'd1;
        if (cnt == 6'd32) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
  assign prod = neg ? -acc : acc;
endmodule
`default_nettype wire

>>> sv/prf_sqdiv.sv
// Shared radix-2 unit: restoring square root and rounded signed division.
// Depends on prf_pkg for the request and response structs.
`default_nettype none
module prf_sqdiv (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire prf_pkg::srq_t  req,
  output prf_pkg::srs_t       rsp
);
  import prf_pkg::*;
  logic [5:0]  cnt;
  logic        busy;
  logic        done;
  op_t         op;
  logic [63:0] rem;
  logic [63:0] val;
  logic [31:0] q;
  logic [31:0] d;
  logic        neg;
  logic [63:0] trial;

  always_comb begin
    if (op == OP_SQRT) trial = (rem << 2 | 64'(val[63:62])) - 64'({q, 2'b01});
    else trial = (rem << 1 | 64'(val[63])) - 64'(d);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
      op <= OP_NONE;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        op <= req.op;
        rem <= '0;
        q <= '0;
        cnt <= '0;
        d <= req.den;
        neg <= req.num[31];
        if (req.op == OP_SQRT) val <= {req.num, 32'd0};
        else val <= {(req.num[31] ? 32'(-req.num) : req.num), 32'd0};
      end else if (busy) begin
        if (op == OP_SQRT) begin
          if (!trial[63]) begin
            rem <= trial;
            q <= {q[30:0], 1'b1};
          end else begin
            rem <= rem << 2 | 64'(val[63:62]);
            q <= {q[30:0], 1'b0};
          end
          val <= val << 2;
          if (cnt == 6'd15) begin
            busy <= 1'b0;
            done <= 1'b1;
          end
        end else begin
          if (!trial[63]) begin
            rem <= trial;
            q <= {q[30:0], 1'b1};
          end else begin
            rem <= rem << 1 | 64'(val[63]);
            q <= {q[30:0], 1'b0};
          end
          val <= val << 1;
          if (cnt == 6'd31) begin
            busy <= 1'b0;
            done <= 1'b1;
          end
        end
        cnt <= cnt + 6'd1;
      end
    end
  end

  // Division result is floor(|num|/den); the caller forms num and den so
  // that the floor is the rounded quotient, and sign fix-up uses remainder.
  always_comb begin
    rsp.done = done;
    rsp.res = q;
    if (op == OP_DIV && neg) rsp.res = (rem != 64'd0) ? -(q + 32'd1) : -q;
  end
endmodule
`default_nettype wire

>>> sv/pose_rebase_to_first_frame.sv
// Pose rebase block: re-expresses each pose relative to the first pose after reset.
// Each pose takes 54 products (63 for the first, which also builds the reference
// translation) through one bit-serial 32x32 multiplier, a square root and three
// divisions in a shared radix-2 unit, then a final state that loads the result.
// The next pose is accepted once the result has been taken.
// Depends on prf_pkg, prf_mul and prf_sqdiv.
`default_nettype none
module pose_rebase_to_first_frame (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] pos_x,
  input  wire logic [31:0] pos_y,
  input  wire logic [31:0] pos_z,
  input  wire logic [15:0] quat_w,
  input  wire logic [15:0] quat_x,
  input  wire logic [15:0] quat_y,
  input  wire logic [15:0] quat_z,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_pos_x,
  output logic [31:0]      out_pos_y,
  output logic [31:0]      out_pos_z,
  output logic [15:0]      out_quat_w,
  output logic [15:0]      out_quat_x,
  output logic [15:0]      out_quat_y,
  output logic [15:0]      out_quat_z
);
  import prf_pkg::*;

  state_t state, state_next;
  logic ref_taken;
  logic signed [31:0] p [3];
  logic signed [15:0] q [4];
  logic signed [15:0] rot [9];
  logic signed [15:0] rref [9];
  logic signed [31:0] tref [3];
  logic signed [15:0] rel [9];
  logic signed [63:0] acc;
  logic [3:0] idx;
  logic [3:0] rrow, rcol;
  logic [1:0] kk;
  logic [1:0] sub;
  logic issued;
  logic mstart, mdone;
  logic signed [31:0] ma, mb;
  logic signed [63:0] mprod;
  srq_t sreq;
  srs_t srsp;
  logic signed [31:0] r;
  logic signed [15:0] qo [4];
  logic [1:0] bi, bj, bk;
  logic tpos;
  logic signed [31:0] dn [3];

  prf_mul u_mul (.clk, .rst, .start(mstart), .a(ma), .b(mb), .done(mdone), .prod(mprod));
  prf_sqdiv u_sd (.clk, .rst, .req(sreq), .rsp(srsp));

  assign in_ready = (state == ST_IDLE) && !out_valid;

  assign rrow = (idx >= 4'd6) ? 4'd6 : ((idx >= 4'd3) ? 4'd3 : 4'd0);
  assign rcol = idx - rrow;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (in_valid && in_ready) state_next = ST_MAT;
      ST_MAT:  if (idx == 4'd8 && sub == 2'd1 && mdone) state_next = ref_taken ? ST_REL : ST_REF;
      ST_REF:  state_next = ST_TRN;
      ST_TRN:  if (idx == 4'd2 && kk == 2'd2 && mdone) state_next = ST_REL;
      ST_REL:  if (idx == 4'd8 && kk == 2'd2 && mdone) state_next = ST_POS;
      ST_POS:  if (idx == 4'd2 && kk == 2'd2 && mdone) state_next = ST_SQRT;
      ST_SQRT: if (srsp.done) state_next = ST_DIV;
      ST_DIV:  if (idx == 4'd2 && srsp.done) state_next = ST_DONE;
      ST_DONE: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Operand selection for the multiplier.
  always_comb begin
    ma = '0;
    mb = '0;
    case (state)
      ST_MAT: begin
        case (idx)
          4'd0, 4'd4, 4'd8: begin
            ma = 32'(q[(idx == 0) ? 2 : 1]);
            mb = 32'(q[(idx == 0) ? 2 : 1]);
            if (sub == 2'd1) begin
              ma = 32'(q[(idx == 8) ? 2 : 3]);
              mb = ma;
            end
          end
          default: begin
            ma = 32'(q[1]);
            mb = 32'(q[2]);
            case (idx)
              4'd1, 4'd3: begin
                ma = sub == 0 ? 32'(q[1]) : 32'(q[3]);
                mb = sub == 0 ? 32'(q[2]) : 32'(q[0]);
              end
              4'd2, 4'd6: begin
                ma = sub == 0 ? 32'(q[1]) : 32'(q[2]);
                mb = sub == 0 ? 32'(q[3]) : 32'(q[0]);
              end
              default: begin
                ma = sub == 0 ? 32'(q[2]) : 32'(q[1]);
                mb = sub == 0 ? 32'(q[3]) : 32'(q[0]);
              end
            endcase
          end
        endcase
      end
      ST_TRN, ST_POS: begin
        ma = 32'(rref[idx * 3 + 4'(kk)]);
        mb = p[kk];
      end
      ST_REL: begin
        ma = 32'(rref[rrow + 4'(kk)]);
        mb = 32'(rot[4'(kk) * 3 + rcol]);
      end
      default: ;
    endcase
  end

  assign mstart = !issued &&
    (state == ST_MAT || state == ST_TRN || state == ST_REL || state == ST_POS);

  // Quaternion from matrix: branch selection.
  always_comb begin
    logic signed [17:0] trc;
    trc = 18'(rel[0]) + 18'(rel[4]) + 18'(rel[8]);
    tpos = trc > 0;
    bi = 2'd0;
    if (rel[4] > rel[0]) bi = 2'd1;
    if (rel[8] > rel[bi * 4]) bi = 2'd2;
    bj = (bi == 2'd2) ? 2'd0 : bi + 2'd1;
    bk = (bj == 2'd2) ? 2'd0 : bj + 2'd1;
    if (tpos) begin
      dn[0] = 32'(rel[7]) - 32'(rel[5]);
      dn[1] = 32'(rel[2]) - 32'(rel[6]);
      dn[2] = 32'(rel[3]) - 32'(rel[1]);
    end else begin
      dn[0] = 32'(rel[bk * 3 + bj]) - 32'(rel[bj * 3 + bk]);
      dn[1] = 32'(rel[bj * 3 + bi]) + 32'(rel[bi * 3 + bj]);
      dn[2] = 32'(rel[bk * 3 + bi]) + 32'(rel[bi * 3 + bk]);
    end
  end

  always_comb begin
    logic signed [31:0] a;
    sreq = '0;
    if (tpos) a = 32'(rel[0]) + 32'(rel[4]) + 32'(rel[8]) + One14;
    else a = 32'(rel[bi * 4]) - 32'(rel[bj * 4]) - 32'(rel[bk * 4]) + One14;
    if (a < 1) a = 1;
    if (!issued && state == ST_SQRT) begin
      sreq.start = 1'b1;
      sreq.op = OP_SQRT;
      sreq.num = a << 14;
    end else if (!issued && state == ST_DIV) begin
      sreq.start = 1'b1;
      sreq.op = OP_DIV;
      sreq.num = (dn[idx[1:0]] <<< 15) + 32'(r <<< 1);
      sreq.den = 32'(r <<< 2);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      ref_taken <= 1'b0;
      out_valid <= 1'b0;
      issued <= 1'b0;
      idx <= '0;
      kk <= '0;
      sub <= '0;
    end else begin
      state <= state_next;
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (mstart || sreq.start) issued <= 1'b1;
      case (state)
        ST_IDLE: if (in_valid && in_ready) begin
          p[0] <= pos_x; p[1] <= pos_y; p[2] <= pos_z;
          q[0] <= quat_w; q[1] <= quat_x; q[2] <= quat_y; q[3] <= quat_z;
          idx <= '0; kk <= '0; sub <= '0; acc <= '0; issued <= 1'b0;
        end
        ST_MAT: if (mdone) begin
          issued <= 1'b0;
          if (sub == 2'd0) begin
            acc <= mprod;
            sub <= 2'd1;
          end else begin
            logic signed [63:0] e;
            if (idx == 0 || idx == 4 || idx == 8) e = 64'sd268435456 - 2 * (acc + mprod);
            else if (idx == 1 || idx == 5 || idx == 6) e = 2 * (acc - mprod);
            else e = 2 * (acc + mprod);
            rot[idx] <= sat14(rsh14(e));
            sub <= 2'd0;
            idx <= (idx == 4'd8) ? 4'd0 : idx + 4'd1;
            acc <= '0;
          end
        end
        ST_REF: begin
          for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++) rref[i * 3 + j] <= rot[j * 3 + i];
          ref_taken <= 1'b1;
          idx <= '0; kk <= '0; acc <= '0; issued <= 1'b0;
        end
        ST_TRN, ST_REL, ST_POS: if (mdone) begin
          issued <= 1'b0;
          if (kk != 2'd2) begin
            acc <= acc + mprod;
            kk <= kk + 2'd1;
          end else begin
            logic signed [63:0] s;
            s = acc + mprod;
            if (state == ST_TRN) tref[idx[1:0]] <= sat32(rsh14(-s));
            else if (state == ST_REL) rel[idx] <= sat14(rsh14(s));
            else qo[0] <= qo[0];
            if (state == ST_POS) begin
              case (idx)
                4'd0: out_pos_x <= sat32(rsh14(s) + 64'(tref[0]));
                4'd1: out_pos_y <= sat32(rsh14(s) + 64'(tref[1]));
                default: out_pos_z <= sat32(rsh14(s) + 64'(tref[2]));
              endcase
            end
            kk <= '0;
            acc <= '0;
            idx <= ((state == ST_REL && idx == 4'd8) || (state != ST_REL && idx == 4'd2))
                   ? 4'd0 : idx + 4'd1;
          end
        end
        ST_SQRT: if (srsp.done) begin
          r <= srsp.res;
          issued <= 1'b0;
          idx <= '0;
        end
        ST_DIV: if (srsp.done) begin
          issued <= 1'b0;
          if (tpos) qo[idx[1:0] + 2'd1] <= sat14(64'(signed'(srsp.res)));
          else if (idx == 0) qo[0] <= sat14(64'(signed'(srsp.res)));
          else if (idx == 1) qo[bj + 2'd1] <= sat14(64'(signed'(srsp.res)));
          else qo[bk + 2'd1] <= sat14(64'(signed'(srsp.res)));
          idx <= idx + 4'd1;
        end
        ST_DONE: begin
          logic signed [15:0] dg;
          dg = sat14(64'((r + 32'sd1) >>> 1));
          out_quat_w <= tpos ? dg : qo[0];
          out_quat_x <= (!tpos && bi == 2'd0) ? dg : qo[1];
          out_quat_y <= (!tpos && bi == 2'd1) ? dg : qo[2];
          out_quat_z <= (!tpos && bi == 2'd2) ? dg : qo[3];
          out_valid <= 1'b1;
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

>>> sv/prf_checker.sv
// Port-level checker for the pose rebase block, bound to the top level.
// Depends on the assertion macro header.
`default_nettype none
`include "pose_rebase_to_first_frame_macros.svh"
module prf_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic [15:0] out_quat_w
);
  `PR_ASSERT_IMPL(a_no_overlap, clk, rst, out_valid, !in_ready)
  `PR_ASSERT_NEXT(a_busy_after_take, clk, rst, in_valid && in_ready, !in_ready)
  `PR_ASSERT_NEXT(a_hold_out, clk, rst, out_valid && !out_ready, out_valid && $stable(out_quat_w))
endmodule
bind pose_rebase_to_first_frame prf_checker u_chk (.clk, .rst, .in_valid, .in_ready,
  .out_valid, .out_ready, .out_quat_w);
`default_nettype wire
